[hdl/rgb_to_hsv_macros.svh]
// ---------------------------------------------------------------------------
// RGB to HSV assertion macros
// Shared concurrent assertion forms for the RGB to HSV converter.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_MACROS_SVH
`define RGB_TO_HSV_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/rth_pkg.sv]
// ---------------------------------------------------------------------------
// RGB to HSV package
// Constants and word types shared by the converter modules.
// ---------------------------------------------------------------------------
package rth_pkg;

   // Fractional bits of the saturation result (at most 12 while SAT_W stays 13).
   localparam int SAT_FRAC_BITS = 12;

   localparam int CH_W   = 8;
   localparam int HUE_W  = 9;
   localparam int SAT_W  = 13;
   // One divider cell per quotient bit of the saturation division.
   localparam int QBITS  = SAT_FRAC_BITS + 1;
   // Partial remainders stay below a 9-bit divisor (twice an 8-bit value).
   localparam int REM_W  = CH_W + 1;
   localparam int NUM_W  = QBITS + REM_W;
   // The hue quotient never exceeds 60.
   localparam int HQ_W   = 6;
   // Cycles from an accepted word to the edge that takes its result.
   localparam int LATENCY = QBITS + 2;

   typedef enum logic [1:0] {
      BR_RED   = 2'd0,
      BR_GREEN = 2'd1,
      BR_BLUE  = 2'd2
   } rth_branch_type;

   typedef struct packed {
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } rth_req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_deg;
      logic [SAT_W-1:0] sat_frac;
      logic [CH_W-1:0]  value_level;
   } rth_rsp_type;

   // Per-pixel facts that ride along the divider chain unchanged.
   typedef struct packed {
      logic [CH_W-1:0] value_level;
      logic            grey;
      rth_branch_type  branch;
      logic            neg;
   } rth_meta_type;

   // Output of the front stage.
   typedef struct packed {
      rth_meta_type    meta;
      logic [CH_W-1:0] delta;
      logic [CH_W-1:0] mag;
   } rth_prep_type;

   // One restoring division in flight: remainder, divisor, and the dividend
   // bits still to be shifted in, which are replaced by quotient bits.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] dvs;
      logic [QBITS-1:0] acc;
   } rth_lane_type;

   typedef struct packed {
      rth_meta_type meta;
      rth_lane_type sat;
      rth_lane_type hue;
   } rth_stage_type;

endpackage

[hdl/rth_prep.sv]
// ---------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max, min and the hue branch of a pixel and registers them.
// ---------------------------------------------------------------------------
module rth_prep
   import rth_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rth_req_type  in_pixel,
   output logic         out_valid,
   output rth_prep_type out_prep
);

   logic         valid_ff;
   logic         valid_in;
   rth_prep_type prep_ff;
   rth_prep_type prep_in;

   logic [CH_W-1:0] mx;
   logic [CH_W-1:0] mn;
   logic [CH_W-1:0] hi;
   logic [CH_W-1:0] lo;

   always_comb begin
      mx = in_pixel.red_in;
      mn = in_pixel.red_in;
      if (in_pixel.green_in > mx) mx = in_pixel.green_in;
      if (in_pixel.blue_in > mx)  mx = in_pixel.blue_in;
      if (in_pixel.green_in < mn) mn = in_pixel.green_in;
      if (in_pixel.blue_in < mn)  mn = in_pixel.blue_in;

      // The hue numerator is (hi - lo) for the winning channel.
      if (mx == in_pixel.red_in) begin
         prep_in.meta.branch = BR_RED;
         hi = in_pixel.green_in;
         lo = in_pixel.blue_in;
      end else if (mx == in_pixel.green_in) begin
         prep_in.meta.branch = BR_GREEN;
         hi = in_pixel.blue_in;
         lo = in_pixel.red_in;
      end else begin
         prep_in.meta.branch = BR_BLUE;
         hi = in_pixel.red_in;
         lo = in_pixel.green_in;
      end

      prep_in.meta.value_level = mx;
      prep_in.meta.neg         = hi < lo;
      prep_in.meta.grey        = mx == mn;
      prep_in.delta            = mx - mn;
      prep_in.mag              = (hi < lo) ? (lo - hi) : (hi - lo);
      valid_in                 = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prep_ff <= prep_in;
   end

   assign out_valid = valid_ff;
   assign out_prep  = prep_ff;

endmodule

[hdl/rth_cell.sv]
// ---------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step for both the saturation and the hue lane.
// ---------------------------------------------------------------------------
module rth_cell
   import rth_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  rth_stage_type in_stage,
   output logic          out_valid,
   output rth_stage_type out_stage
);

   logic          valid_ff;
   logic          valid_in;
   rth_stage_type stage_ff;
   rth_stage_type stage_in;

   logic [REM_W:0] sat_t;
   logic [REM_W:0] hue_t;
   logic           sat_ge;
   logic           hue_ge;

   always_comb begin
      // Bring down the next dividend bit and try to subtract the divisor.
      sat_t  = {in_stage.sat.rem, in_stage.sat.acc[QBITS-1]};
      hue_t  = {in_stage.hue.rem, in_stage.hue.acc[QBITS-1]};
      sat_ge = sat_t >= {1'b0, in_stage.sat.dvs};
      hue_ge = hue_t >= {1'b0, in_stage.hue.dvs};

      stage_in         = in_stage;
      stage_in.sat.rem = sat_ge ? REM_W'(sat_t - {1'b0, in_stage.sat.dvs})
                                : sat_t[REM_W-1:0];
      stage_in.hue.rem = hue_ge ? REM_W'(hue_t - {1'b0, in_stage.hue.dvs})
                                : hue_t[REM_W-1:0];
      stage_in.sat.acc = {in_stage.sat.acc[QBITS-2:0], sat_ge};
      stage_in.hue.acc = {in_stage.hue.acc[QBITS-2:0], hue_ge};
      valid_in         = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[hdl/rth_post.sv]
// ---------------------------------------------------------------------------
// RGB to HSV output stage
// Turns the two quotients into hue and saturation and registers the word.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_macros.svh"

module rth_post
   import rth_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  rth_stage_type in_stage,
   output logic          rsp_strobe,
   output rth_rsp_type   rsp_hsv
);

   localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(360);
   localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(120);
   localparam logic [HUE_W-1:0] HUE_BLUE  = HUE_W'(240);

   logic        strobe_ff;
   logic        strobe_in;
   rth_rsp_type rsp_ff;
   rth_rsp_type rsp_in;

   logic [HUE_W-1:0] q;
   logic             tie;
   logic [HUE_W-1:0] sub;
   logic [HUE_W-1:0] base;
   logic [HUE_W-1:0] sum;

   always_comb begin
      q   = HUE_W'(in_stage.hue.acc[HQ_W-1:0]);
      // A zero remainder means 60*mag/delta sat exactly halfway.
      tie = in_stage.hue.rem == '0;
      // Green and blue offsets below the base round toward the base on a tie.
      sub = (in_stage.meta.neg && (in_stage.meta.branch != BR_RED) && tie)
            ? (q - HUE_W'(1)) : q;

      case (in_stage.meta.branch)
         BR_RED:   base = in_stage.meta.neg ? HUE_FULL : '0;
         BR_GREEN: base = HUE_GREEN;
         default:  base = HUE_BLUE;
      endcase

      sum = in_stage.meta.neg ? (base - sub) : (base + sub);

      rsp_in.hue_deg     = (in_stage.meta.grey || (sum == HUE_FULL)) ? '0 : sum;
      rsp_in.sat_frac    = (in_stage.meta.value_level == '0) ? '0
                                                             : SAT_W'(in_stage.sat.acc);
      rsp_in.value_level = in_stage.meta.value_level;
      strobe_in          = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_hsv    = rsp_ff;

   `RTH_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_strobe, rsp_hsv.hue_deg < HUE_FULL, "hue out of range")
   `RTH_ASSERT_IMPLY(a_grey_hue, clock, reset, rsp_strobe && (rsp_hsv.sat_frac == '0), rsp_hsv.hue_deg == '0, "zero saturation with nonzero hue")

endmodule

[hdl/rgb_to_hsv.sv]
// ---------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per clock into hue, saturation and value.
// ---------------------------------------------------------------------------
// A pixel word is taken at every rising edge where start is high and busy
// is low, and busy is high only while reset is asserted, so a new pixel may
// be offered in every cycle. Each result word appears on rsp_hsv for exactly
// one cycle with rsp_strobe high. Results come out in the order the pixels
// went in. The receiver has no way to hold a result back, so it must take
// the word in the cycle the strobe marks.
// The pipeline is the divider chain: one cell per quotient bit of the
// saturation, with one register stage in front and the output register
// behind it.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_macros.svh"

module rgb_to_hsv
   import rth_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rth_req_type req_pixel,
   output logic        rsp_strobe,
   output rth_rsp_type rsp_hsv
);

   logic          accept;
   logic          prep_valid;
   rth_prep_type  prep;
   rth_stage_type load;
   logic [NUM_W-1:0] hue_num;

   // Index 0 feeds the first cell; index QBITS is the chain output.
   logic          chain_valid [QBITS+1];
   rth_stage_type chain_stage [QBITS+1];

   // The pipeline never stalls, so the only time a word is refused is while
   // the block is held in reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Front stage: channel max and min, the branch of the hue formula, and
   // the magnitude and sign of the hue numerator.
   rth_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_pixel),
      .out_valid (prep_valid),
      .out_prep  (prep)
   );

   // Set up both divisions for the chain. Saturation computes
   // (2*delta*2^F + max) / (2*max); the upper part of that dividend is delta,
   // which is already below the divisor, and its low bits are max. Hue
   // computes (120*mag + delta) / (2*delta), giving 60*mag/delta rounded
   // half up, with the remainder telling whether it was an exact tie.
   always_comb begin
      hue_num = NUM_W'(prep.mag) * NUM_W'(120) + NUM_W'(prep.delta);

      load.meta    = prep.meta;
      load.sat.rem = {1'b0, prep.delta};
      load.sat.dvs = {prep.meta.value_level, 1'b0};
      load.sat.acc = QBITS'(prep.meta.value_level);
      load.hue.rem = hue_num[NUM_W-1 -: REM_W];
      load.hue.dvs = {prep.delta, 1'b0};
      load.hue.acc = hue_num[QBITS-1:0];
   end

   assign chain_valid[0] = prep_valid;
   assign chain_stage[0] = load;

   // Each cell resolves one quotient bit of both divisions and hands the
   // partial remainders to its neighbor on the next clock.
   for (genvar i = 0; i < QBITS; i++) begin : g_cell
      rth_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   // Output stage: hue assembly from branch, sign and rounded quotient,
   // the black-pixel case of saturation, and the result register.
   rth_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[QBITS]),
      .in_stage   (chain_stage[QBITS]),
      .rsp_strobe (rsp_strobe),
      .rsp_hsv    (rsp_hsv)
   );

   // Every accepted pixel produces exactly one strobe, a fixed time later,
   // and no strobe appears without a pixel behind it.
   `RTH_ASSERT_NEXT(a_accept_to_strobe, clock, reset, $past(accept, LATENCY - 1), rsp_strobe, "result missing for accepted pixel")
   `RTH_ASSERT_IMPLY(a_strobe_from_accept, clock, reset, rsp_strobe, $past(accept, LATENCY), "result without accepted pixel")

endmodule

[sim/rth_checker.sv]
// ---------------------------------------------------------------------------
// RGB to HSV result checker
// Watches the pixel and result channels of the converter, works out the HSV
// word that each accepted pixel must produce and compares the results in
// order, field by field.
// ---------------------------------------------------------------------------
module rth_checker
   import rth_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  rth_req_type req_pixel,
   input  logic        rsp_strobe,
   input  rth_rsp_type rsp_hsv,
   output int unsigned mismatches,
   output int unsigned words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_MAX = 10;

   rth_rsp_type hsv_expected[$];
   int unsigned bad_words = 0;

   // Rounds num/den to the nearest integer, ties away from zero; den > 0.
   function automatic int div_round_away(input int num, input int den);
      if (num >= 0) begin
         return (2 * num + den) / (2 * den);
      end
      return -((2 * (-num) + den) / (2 * den));
   endfunction

   function automatic rth_rsp_type hsv_of(input rth_req_type px);
      int             r;
      int             g;
      int             b;
      int             hi;
      int             lo;
      int             delta;
      int             hue;
      logic [63:0]    sat;
      rth_branch_type branch;
      rth_rsp_type    word;
      r = int'(px.red_in);
      g = int'(px.green_in);
      b = int'(px.blue_in);
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      if (hi == 0) begin
         sat = '0;
      end else begin
         sat = ((64'(delta) << SAT_FRAC_BITS) * 2 + 64'(hi)) / (2 * 64'(hi));
      end
      // Ties between channels resolve red first, then green.
      if (hi == r) begin
         branch = BR_RED;
      end else if (hi == g) begin
         branch = BR_GREEN;
      end else begin
         branch = BR_BLUE;
      end
      if (delta == 0) begin
         hue = 0;
      end else begin
         case (branch)
            BR_RED: begin
               hue = div_round_away(60 * (g - b), delta);
               if (hue < 0) hue = hue + 360;
            end
            BR_GREEN: hue = div_round_away(60 * (b - r) + 120 * delta, delta);
            default:  hue = div_round_away(60 * (r - g) + 240 * delta, delta);
         endcase
      end
      word.hue_deg     = hue[HUE_W-1:0];
      word.sat_frac    = sat[SAT_W-1:0];
      word.value_level = hi[CH_W-1:0];
      return word;
   endfunction

   always @(posedge clock) begin
      rth_rsp_type want;
      if (reset) begin
         hsv_expected.delete();
      end else begin
         if (rsp_strobe) begin
            if (hsv_expected.size() == 0) begin
               bad_words = bad_words + 1;
               if (bad_words <= REPORT_MAX) begin
                  $display("%0t: unexpected result word hue %0d sat %0d val %0d", $realtime,
                           rsp_hsv.hue_deg, rsp_hsv.sat_frac, rsp_hsv.value_level);
               end
            end else begin
               want = hsv_expected.pop_front();
               if (rsp_hsv.hue_deg !== want.hue_deg || rsp_hsv.sat_frac !== want.sat_frac ||
                   rsp_hsv.value_level !== want.value_level) begin
                  bad_words = bad_words + 1;
                  if (bad_words <= REPORT_MAX) begin
                     $display("%0t: hsv mismatch: expected hue %0d sat %0d val %0d, %s",
                              $realtime, want.hue_deg, want.sat_frac, want.value_level,
                              $sformatf("got %0d %0d %0d", rsp_hsv.hue_deg,
                                        rsp_hsv.sat_frac, rsp_hsv.value_level));
                  end
               end
            end
         end
         // A pixel taken at this edge cannot have its result at the same edge.
         if (start && !busy) begin
            hsv_expected.push_back(hsv_of(req_pixel));
         end
      end
      mismatches    <= bad_words;
      words_pending <= hsv_expected.size();
   end

endmodule

[sim/tb_rgb_to_hsv.sv]
// ---------------------------------------------------------------------------
// RGB to HSV converter testbench
// Feeds directed and random pixels, in bursts or with random gaps, into the
// converter; the checker beside it checks every result word.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsv;
   timeunit 1ns;
   timeprecision 1ps;
   import rth_pkg::*;

   // Number of random pixels after the directed ones.
   localparam int NUM_RANDOM   = 500;
   // Cycles without any accepted word or result word before the run is
   // declared hung.
   localparam int IDLE_LIMIT   = 200;
   // Extra cycles after the last expected word, to catch stray results.
   localparam int DRAIN_CYCLES = LATENCY + 5;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   rth_req_type req_pixel;
   logic        rsp_strobe;
   rth_rsp_type rsp_hsv;
   int unsigned hsv_mismatches;
   int unsigned hsv_pending;
   int unsigned idle_cycles;
   // While set, pixels are offered back to back with no gaps at all.
   logic        burst_mode;

   rgb_to_hsv dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .rsp_strobe (rsp_strobe),
      .rsp_hsv    (rsp_hsv)
   );

   rth_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel     (req_pixel),
      .rsp_strobe    (rsp_strobe),
      .rsp_hsv       (rsp_hsv),
      .mismatches    (hsv_mismatches),
      .words_pending (hsv_pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The watchdog restarts on every edge that moves a word in either
   // direction. Reset cycles never count against it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb_rgb_to_hsv NOT OK");
            $finish;
         end
      end
   end

   // Offers one pixel word. The task is entered just after a rising edge,
   // and it returns just after the edge at which the word was taken, with
   // start still high. A gap lowers start first, so start is never lowered
   // and raised again in the same time step.
   task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_pixel.red_in    <= r;
      req_pixel.green_in  <= g;
      req_pixel.blue_in   <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds the sender back until the checker has seen every result word
   // it is waiting for.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (hsv_pending != 0) @(posedge clock);
   endtask

   initial begin
      int              n;
      int              kind;
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;

      reset       = 1'b1;
      start       = 1'b0;
      req_pixel   = '0;
      burst_mode  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels. Black and grey exercise the zero saturation and
      // zero hue cases, the pure and mixed primaries walk every hue branch,
      // and the tied pairs check that red wins over green and green over
      // blue. Magenta and the reddish pixels give a negative red-branch hue
      // that has to wrap around by 360 degrees. The last pair lands exactly
      // on half a degree, once above and once below zero.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd200, 8'd10, 8'd50);
      send_pixel(8'd10, 8'd200, 8'd50);
      send_pixel(8'd10, 8'd50, 8'd200);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd1, 8'd0);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd85, 8'd170, 8'd255);
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd255, 8'd248, 8'd247);
      send_pixel(8'd255, 8'd247, 8'd248);

      // Let the pipeline empty once before the random part starts.
      wait_for_results();

      for (n = 0; n < NUM_RANDOM; n++) begin
         // Choose anew between bursts and gapped traffic every fifty words.
         if (n % 50 == 0) begin
            burst_mode = ($urandom_range(0, 2) == 0);
         end
         if (n == NUM_RANDOM / 2) begin
            wait_for_results();
         end
         r = CH_W'($urandom);
         g = CH_W'($urandom);
         b = CH_W'($urandom);
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               // Grey pixel.
               g = r;
               b = r;
            end
            1: begin
               // Two channels tied, which may or may not be the maximum.
               case ($urandom_range(0, 2))
                  0:       g = r;
                  1:       b = g;
                  default: b = r;
               endcase
            end
            2: begin
               // Very dark pixels, where the divisions are coarsest.
               r = CH_W'($urandom_range(0, 3));
               g = CH_W'($urandom_range(0, 3));
               b = CH_W'($urandom_range(0, 3));
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end

      // All words are in; wait for the last results and a little longer.
      start <= 1'b0;
      @(posedge clock);
      while (hsv_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (hsv_mismatches == 0 && hsv_pending == 0) begin
         $display("tb_rgb_to_hsv OK");
      end else begin
         $display("tb_rgb_to_hsv NOT OK");
      end
      $finish;
   end

endmodule
